/* rtl/triangle_plane_segment_defines.svh */
// assertion macros for triangle_plane_segment
`ifndef TRIANGLE_PLANE_SEGMENT_DEFINES_SVH
`define TRIANGLE_PLANE_SEGMENT_DEFINES_SVH

// implication checked on every edge outside reset
`define TPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// condition that must never be seen outside reset
`define TPS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed");

`endif

/* rtl/tps_pkg.sv */
// ----------------------------------------------------------------------------
// tps_pkg
// request and result types of the triangle plane cutter
// ----------------------------------------------------------------------------
`default_nettype none
package tps_pkg;

  typedef struct packed {
    logic signed [31:0] v0_x;
    logic signed [31:0] v0_y;
    logic signed [31:0] v0_z;
    logic signed [31:0] v1_x;
    logic signed [31:0] v1_y;
    logic signed [31:0] v1_z;
    logic signed [31:0] v2_x;
    logic signed [31:0] v2_y;
    logic signed [31:0] v2_z;
    logic signed [31:0] plane_height;
  } tps_in_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
  } tps_out_t;

  localparam int EdgeCount = 3;

endpackage
`default_nettype wire

/* rtl/tps_interp.sv */
// ----------------------------------------------------------------------------
// tps_interp
// pipelined a +/- trunc(num*span/den): one multiply stage, one restoring
// division step per stage, then a final add
// ----------------------------------------------------------------------------
`default_nettype none
module tps_interp #(
  parameter int W = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  input  wire logic         in_tag,
  input  wire logic [W-1:0] in_a,
  input  wire logic [W:0]   in_num,
  input  wire logic [W:0]   in_span,
  input  wire logic [W:0]   in_den,
  input  wire logic         in_neg,
  output logic              out_valid,
  output logic              out_tag,
  output logic [W-1:0]      out_res
);

  localparam int Steps = W + 1;

  logic [2*W+1:0] prod;
  logic [Steps:0] v_r;
  logic [W:0]     rem_r [0:Steps];
  logic [W:0]     lo_r  [0:Steps];
  logic [W:0]     q_r   [0:Steps];
  logic [W:0]     den_r [0:Steps];
  logic [W-1:0]   a_r   [0:Steps];
  logic           neg_r [0:Steps];
  logic           tag_r [0:Steps];
  logic [W+1:0]   rem2  [1:Steps];
  logic           ge    [1:Steps];
  logic [W:0]     rem_nxt [1:Steps];
  logic [W:0]     sum;
  logic           valid_r;
  logic           tag_out_r;
  logic [W-1:0]   res_r;

  assign prod = in_num * in_span;

  always_comb begin
    for (int k = 1; k <= Steps; k++) begin
      rem2[k]    = {rem_r[k-1], lo_r[k-1][W]};
      ge[k]      = rem2[k] >= {1'b0, den_r[k-1]};
      rem_nxt[k] = ge[k] ? (W+1)'(rem2[k] - {1'b0, den_r[k-1]}) : rem2[k][W:0];
    end
  end

  always_comb begin
    if (neg_r[Steps]) begin
      sum = {a_r[Steps][W-1], a_r[Steps]} - q_r[Steps];
    end else begin
      sum = {a_r[Steps][W-1], a_r[Steps]} + q_r[Steps];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= '0;
      valid_r <= 1'b0;
    end else begin
      v_r     <= {v_r[Steps-1:0], in_valid};
      valid_r <= v_r[Steps];
    end
    // high half of the product is already below den, so W+1 steps suffice
    rem_r[0] <= prod[2*W+1:W+1];
    lo_r[0]  <= prod[W:0];
    q_r[0]   <= '0;
    den_r[0] <= in_den;
    a_r[0]   <= in_a;
    neg_r[0] <= in_neg;
    tag_r[0] <= in_tag;
    for (int k = 1; k <= Steps; k++) begin
      rem_r[k] <= rem_nxt[k];
      lo_r[k]  <= {lo_r[k-1][W-1:0], 1'b0};
      q_r[k]   <= {q_r[k-1][W-1:0], ge[k]};
      den_r[k] <= den_r[k-1];
      a_r[k]   <= a_r[k-1];
      neg_r[k] <= neg_r[k-1];
      tag_r[k] <= tag_r[k-1];
    end
    res_r     <= sum[W-1:0];
    tag_out_r <= tag_r[Steps];
  end

  assign out_valid = valid_r;
  assign out_tag   = tag_out_r;
  assign out_res   = res_r;

endmodule
`default_nettype wire

/* rtl/triangle_plane_segment.sv */
// path: input register, edge-select register, four interp lanes, output register
// throughput: one request per cycle, busy stays low; the depth is set by the
// restoring divider, one quotient bit per pipeline stage
// reset: synchronous active-low rst_n clears all valid bits, no result in flight
// the receiver cannot stall, out_valid is a one-cycle strobe
`default_nettype none
module triangle_plane_segment
  import tps_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire tps_in_t  in_data,
  output logic          out_valid,
  output tps_out_t      out_data
);

  localparam int W  = COORD_WIDTH;
  localparam int W1 = COORD_WIDTH + 1;

  tps_in_t in_r;
  logic    in_v_r;

  logic signed [W-1:0] cx [0:EdgeCount-1];
  logic signed [W-1:0] cy [0:EdgeCount-1];
  logic signed [W-1:0] cz [0:EdgeCount-1];
  logic signed [W-1:0] h;
  logic signed [W:0]   e_num [0:EdgeCount-1];
  logic signed [W:0]   e_den [0:EdgeCount-1];
  logic signed [W:0]   e_spx [0:EdgeCount-1];
  logic signed [W:0]   e_spy [0:EdgeCount-1];
  logic [EdgeCount-1:0] crosses;
  logic [1:0]          sel [0:1];
  logic                hit;

  logic          s_v_r;
  logic          hit_r;
  logic [W-1:0]  ax_r   [0:1];
  logic [W-1:0]  ay_r   [0:1];
  logic [W:0]    num_r  [0:1];
  logic [W:0]    den_r  [0:1];
  logic [W:0]    spx_r  [0:1];
  logic [W:0]    spy_r  [0:1];
  logic          negx_r [0:1];
  logic          negy_r [0:1];

  logic          iv    [0:3];
  logic          itag  [0:3];
  logic [W-1:0]  ires  [0:3];
  logic          res_v;
  logic          res_hit;

  tps_out_t out_r;
  logic     out_v_r;

  function automatic logic [W:0] mag(input logic signed [W:0] v);
    return v[W] ? (W1)'(-v) : v;
  endfunction

  assign busy = 1'b0;

  always_comb begin
    cx[0] = W'($unsigned(in_r.v0_x));
    cy[0] = W'($unsigned(in_r.v0_y));
    cz[0] = W'($unsigned(in_r.v0_z));
    cx[1] = W'($unsigned(in_r.v1_x));
    cy[1] = W'($unsigned(in_r.v1_y));
    cz[1] = W'($unsigned(in_r.v1_z));
    cx[2] = W'($unsigned(in_r.v2_x));
    cy[2] = W'($unsigned(in_r.v2_y));
    cz[2] = W'($unsigned(in_r.v2_z));
    h     = W'($unsigned(in_r.plane_height));
    for (int i = 0; i < EdgeCount; i++) begin
      int j;
      j = (i + 1 == EdgeCount) ? 0 : i + 1;
      crosses[i] = (cz[i] > h && cz[j] < h) || (cz[i] < h && cz[j] > h);
      e_num[i] = W1'(h) - W1'(cz[i]);
      e_den[i] = W1'(cz[j]) - W1'(cz[i]);
      e_spx[i] = W1'(cx[j]) - W1'(cx[i]);
      e_spy[i] = W1'(cy[j]) - W1'(cy[i]);
    end
    hit = (crosses == 3'b011) || (crosses == 3'b110) || (crosses == 3'b101);
    // first two crossing edges in edge order
    if (crosses[0]) begin
      sel[0] = 2'd0;
      sel[1] = crosses[1] ? 2'd1 : 2'd2;
    end else begin
      sel[0] = 2'd1;
      sel[1] = 2'd2;
    end
  end

  // the four lanes run in lockstep
  assign res_v   = iv[0] && iv[1] && iv[2] && iv[3];
  assign res_hit = itag[0] && itag[1] && itag[2] && itag[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      s_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= start && !busy;
      s_v_r   <= in_v_r;
      out_v_r <= res_v;
    end
    in_r  <= in_data;
    hit_r <= hit;
    for (int s = 0; s < 2; s++) begin
      ax_r[s]   <= cx[sel[s]];
      ay_r[s]   <= cy[sel[s]];
      num_r[s]  <= mag(e_num[sel[s]]);
      den_r[s]  <= mag(e_den[sel[s]]);
      spx_r[s]  <= mag(e_spx[sel[s]]);
      spy_r[s]  <= mag(e_spy[sel[s]]);
      negx_r[s] <= e_num[sel[s]][W] ^ e_spx[sel[s]][W] ^ e_den[sel[s]][W];
      negy_r[s] <= e_num[sel[s]][W] ^ e_spy[sel[s]][W] ^ e_den[sel[s]][W];
    end
    out_r.hit     <= res_hit;
    out_r.start_x <= res_hit ? 32'(ires[0]) : '0;
    out_r.start_y <= res_hit ? 32'(ires[1]) : '0;
    out_r.end_x   <= res_hit ? 32'(ires[2]) : '0;
    out_r.end_y   <= res_hit ? 32'(ires[3]) : '0;
  end

  tps_interp #(.W(W)) u_sx (
    .clk(clk), .rst_n(rst_n), .in_valid(s_v_r), .in_tag(hit_r),
    .in_a(ax_r[0]), .in_num(num_r[0]), .in_span(spx_r[0]), .in_den(den_r[0]),
    .in_neg(negx_r[0]), .out_valid(iv[0]), .out_tag(itag[0]), .out_res(ires[0])
  );

  tps_interp #(.W(W)) u_sy (
    .clk(clk), .rst_n(rst_n), .in_valid(s_v_r), .in_tag(hit_r),
    .in_a(ay_r[0]), .in_num(num_r[0]), .in_span(spy_r[0]), .in_den(den_r[0]),
    .in_neg(negy_r[0]), .out_valid(iv[1]), .out_tag(itag[1]), .out_res(ires[1])
  );

  tps_interp #(.W(W)) u_ex (
    .clk(clk), .rst_n(rst_n), .in_valid(s_v_r), .in_tag(hit_r),
    .in_a(ax_r[1]), .in_num(num_r[1]), .in_span(spx_r[1]), .in_den(den_r[1]),
    .in_neg(negx_r[1]), .out_valid(iv[2]), .out_tag(itag[2]), .out_res(ires[2])
  );

  tps_interp #(.W(W)) u_ey (
    .clk(clk), .rst_n(rst_n), .in_valid(s_v_r), .in_tag(hit_r),
    .in_a(ay_r[1]), .in_num(num_r[1]), .in_span(spy_r[1]), .in_den(den_r[1]),
    .in_neg(negy_r[1]), .out_valid(iv[3]), .out_tag(itag[3]), .out_res(ires[3])
  );

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

/* rtl/tps_checker.sv */
// ----------------------------------------------------------------------------
// tps_checker
// port-level checks of triangle_plane_segment, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "triangle_plane_segment_defines.svh"
module tps_checker
  import tps_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     start,
  input wire logic     busy,
  input wire logic     out_valid,
  input wire tps_out_t out_data
);

  localparam int Lat = COORD_WIDTH + 6;

  // every request comes out after the fixed latency
  `TPS_ASSERT_IMP(a_req_to_res, clk, rst_n, start && !busy, ##Lat out_valid)
  // no result without a request the fixed latency earlier
  `TPS_ASSERT_IMP(a_res_from_req, clk, rst_n, out_valid, $past(start && !busy, Lat))
  // a miss carries zero points
  `TPS_ASSERT_IMP(a_miss_zero, clk, rst_n, out_valid && !out_data.hit,
    out_data.start_x == 0 && out_data.start_y == 0 && out_data.end_x == 0 && out_data.end_y == 0)
  `TPS_ASSERT_NEVER(a_never_busy, clk, rst_n, busy)

endmodule

bind triangle_plane_segment tps_checker #(.COORD_WIDTH(COORD_WIDTH)) u_tps_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_data(out_data)
);
`default_nettype wire

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the triangle plane cutter
// Triangles are sent through the start/busy command port. Directed cases come
// first, then random ones. A local model works out the segment of each
// accepted request, and every result strobe is checked field by field
// against the oldest expected segment.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tps_pkg::*;

  localparam int LATENCY = 32 + 6;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 1630;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  tps_in_t  in_data = '0;
  logic     out_valid;
  tps_out_t out_data;

  tps_in_t  pending_triangles[$];
  tps_out_t expected_segments[$];
  int       mismatch_count = 0;
  int       cycle_count = 0;
  int       sent_count = 0;

  triangle_plane_segment dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always #6 clk = ~clk;

  // a + (h - za) * (b - a) / (zb - za), quotient truncated toward zero
  function automatic logic signed [31:0] cross_coord(
    input logic signed [31:0] a, input logic signed [31:0] b,
    input logic signed [31:0] za, input logic signed [31:0] zb,
    input logic signed [31:0] h);
    logic signed [127:0] wa, wb, wza, wzb, wh, q;
    wa = a; wb = b; wza = za; wzb = zb; wh = h;
    q = ((wh - wza) * (wb - wa)) / (wzb - wza);
    return 32'(wa + q);
  endfunction

  function automatic tps_out_t cut_triangle(input tps_in_t t);
    logic signed [31:0] vx[3], vy[3], vz[3], px[2], py[2];
    logic signed [31:0] h;
    tps_out_t seg;
    int crossings;
    int j;
    vx = '{t.v0_x, t.v1_x, t.v2_x};
    vy = '{t.v0_y, t.v1_y, t.v2_y};
    vz = '{t.v0_z, t.v1_z, t.v2_z};
    h = t.plane_height;
    crossings = 0;
    px = '{0, 0};
    py = '{0, 0};
    for (int i = 0; i < EdgeCount; i++) begin
      j = (i + 1) % EdgeCount;
      if ((vz[i] > h && vz[j] < h) || (vz[i] < h && vz[j] > h)) begin
        if (crossings < 2) begin
          px[crossings] = cross_coord(vx[i], vx[j], vz[i], vz[j], h);
          py[crossings] = cross_coord(vy[i], vy[j], vz[i], vz[j], h);
        end
        crossings++;
      end
    end
    seg = '0;
    if (crossings == 2) begin
      seg.hit = 1'b1;
      seg.start_x = px[0];
      seg.start_y = py[0];
      seg.end_x = px[1];
      seg.end_y = py[1];
    end
    return seg;
  endfunction

  function automatic logic signed [31:0] rand_coord(input int spread);
    case (spread)
      0: return $signed($urandom());
      1: return $signed($urandom_range(2000)) - 1000;
      default: return $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
    endcase
  endfunction

  // mostly triangles straddling the plane, some with a vertex on it
  function automatic tps_in_t rand_triangle();
    tps_in_t t;
    int spread;
    spread = $urandom_range(2);
    t.v0_x = rand_coord(spread); t.v0_y = rand_coord(spread);
    t.v1_x = rand_coord(spread); t.v1_y = rand_coord(spread);
    t.v2_x = rand_coord(spread); t.v2_y = rand_coord(spread);
    t.v0_z = rand_coord(spread); t.v1_z = rand_coord(spread);
    t.v2_z = rand_coord(spread);
    case ($urandom_range(9))
      0, 1: t.plane_height = rand_coord(spread);
      2: t.plane_height = ($urandom_range(1)) ? t.v0_z : t.v2_z;
      default: t.plane_height = 32'(($signed(64'(t.v0_z)) + $signed(64'(t.v1_z))
                                    + $signed(64'(t.v2_z))) / 3);
    endcase
    return t;
  endfunction

  function automatic void add_triangle(input tps_in_t t);
    pending_triangles = {pending_triangles, t};
  endfunction

  // driver: queue pops on each accepted request
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        expected_segments = {expected_segments, cut_triangle(in_data)};
        void'(pending_triangles.pop_front());
        sent_count++;
      end
      if ((start && busy) || (pending_triangles.size() > 0
          && ((sent_count > 400 && sent_count < 700) || $urandom_range(99) >= 16))) begin
        if (!(start && busy)) begin
          start <= 1'b1;
          in_data <= pending_triangles[0];
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_segments.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %p", out_data);
      end else begin
        tps_out_t exp_seg;
        exp_seg = expected_segments.pop_front();
        if (out_data.hit !== exp_seg.hit || out_data.start_x !== exp_seg.start_x
            || out_data.start_y !== exp_seg.start_y || out_data.end_x !== exp_seg.end_x
            || out_data.end_y !== exp_seg.end_y) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("segment mismatch: expected %p actual %p", exp_seg, out_data);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic tps_in_t flat_triangle(input logic signed [31:0] z0,
    input logic signed [31:0] z1, input logic signed [31:0] z2,
    input logic signed [31:0] h, input logic signed [31:0] xy);
    tps_in_t t;
    t = '{xy, -xy, z0, -xy, xy, z1, xy, xy, z2, h};
    return t;
  endfunction

  initial begin
    // directed: no hit, vertex on plane, extremes
    add_triangle('0);
    add_triangle('1);
    add_triangle(flat_triangle(0, 10, 20, 0, 5));
    add_triangle(flat_triangle(-10, 0, 10, 0, 100));
    add_triangle(flat_triangle(-10, 10, 20, 0, 100));
    add_triangle(flat_triangle(10, -10, 20, 0, 100));
    add_triangle(flat_triangle(10, 20, -10, 0, 100));
    add_triangle(flat_triangle(32'sh8000_0000, 32'sh7fff_ffff,
                               32'sh7fff_ffff, 0, 32'sh7fff_ffff));
    add_triangle(flat_triangle(32'sh7fff_ffff, 32'sh8000_0000,
                               32'sh8000_0000, -1, 32'sh8000_0000));
    add_triangle(flat_triangle(32'sh8000_0000, 32'sh7fff_ffff,
                               32'sh8000_0000, 32'sh7fff_fffe,
                               32'sh8000_0000));
    add_triangle('{32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                   32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
                   32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0});
    add_triangle(flat_triangle(5, 5, 5, 5, 7));
    add_triangle(flat_triangle(-3, 1, 1, 0, -1));
    for (int i = 0; i < RANDOM_ITEMS; i++) add_triangle(rand_triangle());
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_triangles.size() == 0);
    wait (expected_segments.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
